// ===== src/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the round schedule shuffle block.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int          MaxParticipants = 64;
    localparam logic [63:0] MixMul          = 64'd2685821657736338717;

    localparam logic [1:0] ModeLoad  = 2'd0;
    localparam logic [1:0] ModeBlock = 2'd1;
    localparam logic [1:0] ModeQuery = 2'd2;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatEmpty = 2'd1;
    localparam logic [1:0] StatFull  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the input beat
        logic load_write;  // write staging entry, bump count
        logic copy_start;  // reset copy index
        logic copy_step;   // read staging at index (for next write)
        logic copy_write;  // write schedule at index, advance
        logic copy_done;   // set schedule count
        logic mix_start;   // start mix for current position
        logic mix_step;    // advance mix pipeline one stage
        logic div_start;   // start remainder unit
        logic div_step;    // one remainder bit
        logic rd_i;        // read schedule at position i
        logic rd_j;        // read schedule at position j
        logic wr_i;        // write entry j value at i
        logic wr_j;        // write entry i value at j, advance i
        logic q_start;     // start query remainder
        logic q_read;      // read schedule at query index
        logic res_load;    // load result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] mode;
        logic       stage_full;
        logic       stage_empty;
        logic       sched_empty;
        logic       bnum_hit;
        logic       copy_last;
        logic       div_last;
        logic       shuf_last;
    } t_sts;

endpackage

// ===== src/rss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_datapath
// Lists, mixer, shared bit-serial remainder unit and result register.
// ----------------------------------------------------------------------------
module rss_datapath import rss_pkg::*; #(
    parameter int MAX_PARTICIPANTS = MaxParticipants
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_mode,
    input  logic        i_is_first,
    input  logic [15:0] i_load_id,
    input  logic [31:0] i_block_number,
    input  logic [31:0] i_block_seconds,
    input  logic [63:0] i_current_aslot,
    input  logic [31:0] i_slot_offset,
    output logic [15:0] o_picked_id,
    output logic        o_shuffled,
    output logic [1:0]  o_status
);
    localparam int AW = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;
    localparam int CW = $clog2(MAX_PARTICIPANTS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_PARTICIPANTS);

    // Captured beat
    logic [1:0]  r_mode;
    logic        r_first;
    logic [15:0] r_id;
    logic [31:0] r_bsec;
    logic [63:0] r_slot;
    logic        r_wrote;

    // Counts
    logic [CW-1:0] r_stage_cnt, r_sched_cnt;
    logic [CW-1:0] w_eff_cnt;

    // Memories
    logic [15:0] r_stage_mem [MAX_PARTICIPANTS];
    logic [15:0] r_sched_mem [MAX_PARTICIPANTS];
    logic [15:0] r_stage_rd, r_sched_rd, r_val_i;

    // Indexes
    logic [CW-1:0] r_idx;   // copy index and shuffle position i
    logic [CW-1:0] r_j;

    // Mixer
    logic [63:0] r_k;
    logic [2:0]  r_mstage;
    logic [63:0] r_pos_mul;
    logic [63:0] r_acc;
    logic [31:0] r_cross;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;

    // Remainder unit
    logic [63:0] r_num;
    logic [CW-1:0] r_den;
    logic [CW:0] r_rem;
    logic [6:0]  r_dcnt;
    logic [CW:0] w_rem_sh;
    logic [CW:0] w_rem_nx;

    // Result
    logic [15:0] r_pick;
    logic        r_shuf;
    logic [1:0]  r_stat;

    assign w_eff_cnt = r_first ? '0 : r_stage_cnt;

    // Capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_first <= i_is_first;
            r_id    <= i_load_id;
            r_bsec  <= i_block_seconds;
            r_slot  <= i_current_aslot + {32'd0, i_slot_offset};
        end
    end

    // Load accepted flag, clear on capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wrote <= 1'b0;
        end else if (i_cmd.load_write) begin
            r_wrote <= 1'b1;
        end
    end

    // Counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_cnt <= '0;
            r_sched_cnt <= '0;
        end else begin
            if (i_cmd.load_write) begin
                r_stage_cnt <= w_eff_cnt + 1'b1;
            end
            if (i_cmd.copy_done) begin
                r_sched_cnt <= r_stage_cnt;
            end
        end
    end

    // Staging memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_stage_mem[w_eff_cnt[AW-1:0]] <= r_id;
        end
        if (i_cmd.copy_step) begin
            r_stage_rd <= r_stage_mem[r_idx[AW-1:0]];
        end
    end

    // Schedule memory: one write, one registered read per cycle
    logic [AW-1:0] w_sw_addr, w_sr_addr;
    logic [15:0]   w_sw_data;
    logic          w_sw_en;
    always_comb begin
        w_sw_en   = i_cmd.copy_write | i_cmd.wr_i | i_cmd.wr_j;
        w_sw_addr = r_idx[AW-1:0];
        w_sw_data = r_stage_rd;
        if (i_cmd.wr_i) begin
            w_sw_data = r_sched_rd;
        end else if (i_cmd.wr_j) begin
            w_sw_addr = r_j[AW-1:0];
            w_sw_data = r_val_i;
        end
        w_sr_addr = r_idx[AW-1:0];
        if (i_cmd.rd_j) begin
            w_sr_addr = r_j[AW-1:0];
        end else if (i_cmd.q_read) begin
            w_sr_addr = r_rem[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sw_en) begin
            r_sched_mem[w_sw_addr] <= w_sw_data;
        end
        if (i_cmd.rd_i || i_cmd.rd_j || i_cmd.q_read) begin
            r_sched_rd <= r_sched_mem[w_sr_addr];
        end
        if (i_cmd.rd_j) begin
            r_val_i <= r_sched_rd;
        end
    end

    // Index counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_start) begin
            r_idx <= '0;
        end else if (i_cmd.copy_write || i_cmd.wr_j) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Shared 32x32 multiplier for the final product, one partial per stage
    always_comb begin
        w_ma = r_k[31:0];
        w_mb = MixMul[31:0];
        if (r_mstage == 3'd4) begin
            w_ma = r_k[63:32];
        end else if (r_mstage == 3'd5) begin
            w_mb = MixMul[63:32];
        end
    end
    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    // Mixer: position product, xorshift, final product over three stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_start) begin
            r_pos_mul <= 64'(r_idx) * MixMul;
            r_mstage  <= '0;
        end else if (i_cmd.mix_step) begin
            r_mstage <= r_mstage + 1'b1;
            unique case (r_mstage)
                3'd0: r_k <= {r_bsec, 32'd0} + r_pos_mul;
                3'd1: r_k <= (r_k ^ (r_k >> 12)) ^ ((r_k ^ (r_k >> 12)) << 25);
                3'd2: r_k <= r_k ^ (r_k >> 27);
                3'd3: r_acc <= w_prod;
                3'd4: r_cross <= w_prod[31:0];
                3'd5: r_k <= r_acc + {r_cross + w_prod[31:0], 32'd0};
                default: r_k <= r_k;
            endcase
        end
    end

    // Bit-serial remainder
    assign w_rem_sh = {r_rem[CW-1:0], r_num[63]};
    assign w_rem_nx = (w_rem_sh >= {1'b0, r_den}) ? w_rem_sh - {1'b0, r_den} : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num  <= r_k;
            r_den  <= r_sched_cnt - r_idx;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.q_start) begin
            r_num  <= r_slot;
            r_den  <= r_sched_cnt;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= w_rem_nx;
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_i) begin
            r_j <= r_idx + r_rem[CW-1:0];
        end
    end

    // Block-number test: its own remainder on the shared step command, mode 1 case
    logic [CW-1:0] r_bden;
    logic [CW:0]   r_brem;
    logic [31:0]   r_bn;
    logic [CW:0]   w_brem_sh, w_brem_nx;
    assign w_brem_sh = {r_brem[CW-1:0], r_bn[31]};
    assign w_brem_nx = (w_brem_sh >= {1'b0, r_bden}) ? w_brem_sh - {1'b0, r_bden}
                                                     : w_brem_sh;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bn   <= i_block_number;
            r_bden <= r_stage_cnt;
            r_brem <= '0;
        end else if (i_cmd.div_step && r_mode == ModeBlock && !i_cmd.copy_step) begin
            r_bn   <= {r_bn[30:0], 1'b0};
            r_brem <= w_brem_nx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick <= '0;
            r_shuf <= 1'b0;
            r_stat <= StatOk;
        end else if (i_cmd.res_load) begin
            r_pick <= '0;
            r_shuf <= 1'b0;
            r_stat <= StatOk;
            unique case (r_mode)
                ModeLoad: begin
                    if (!r_wrote) r_stat <= StatFull;
                end
                ModeBlock: begin
                    if (r_stage_cnt == '0) r_stat <= StatEmpty;
                    else r_shuf <= i_cmd.copy_done;
                end
                ModeQuery: begin
                    if (r_sched_cnt == '0) r_stat <= StatEmpty;
                    else r_pick <= r_sched_rd;
                end
                default: ;
            endcase
        end
    end

    assign o_picked_id = r_pick;
    assign o_shuffled  = r_shuf;
    assign o_status    = r_stat;

    // Status
    assign o_sts.mode        = r_mode;
    assign o_sts.stage_full  = (w_eff_cnt >= MaxCnt);
    assign o_sts.stage_empty = (r_stage_cnt == '0);
    assign o_sts.sched_empty = (r_sched_cnt == '0);
    assign o_sts.bnum_hit    = (r_brem == '0);
    assign o_sts.copy_last   = (r_idx == r_stage_cnt - 1'b1);
    assign o_sts.div_last    = (r_dcnt == 7'd63);
    assign o_sts.shuf_last   = (r_idx == r_sched_cnt - 1'b1);
endmodule

// ===== src/rss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer for load, copy, shuffle and query operations.
// ----------------------------------------------------------------------------
module rss_ctrl import rss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DISP  = 15'b000000000000010,
        S_BDIV  = 15'b000000000000100,
        S_CRD   = 15'b000000000001000,
        S_CWR   = 15'b000000000010000,
        S_MIX   = 15'b000000000100000,
        S_DSTA  = 15'b000000001000000,
        S_DIV   = 15'b000000010000000,
        S_RDI   = 15'b000000100000000,
        S_RDJ   = 15'b000001000000000,
        S_WRI   = 15'b000010000000000,
        S_WRJ   = 15'b000100000000000,
        S_QDIV  = 15'b001000000000000,
        S_QRD   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_v, n_out_v;
    logic   r_built, n_built;
    logic [2:0] r_mcnt, n_mcnt;
    logic [5:0] r_bcnt, n_bcnt;
    logic   w_take;

    assign w_take  = r_out_v && !i_stall;
    assign o_valid = r_out_v;
    assign o_stall = !(r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_built <= 1'b0;
            r_mcnt  <= '0;
            r_bcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_built <= n_built;
            r_mcnt  <= n_mcnt;
            r_bcnt  <= n_bcnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_out_v = r_out_v & ~w_take;
        n_built = r_built;
        n_mcnt  = r_mcnt;
        n_bcnt  = r_bcnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_built = 1'b0;
                priority if (i_sts.mode == ModeLoad) begin
                    o_cmd.load_write = !i_sts.stage_full;
                    n_state = S_DONE;
                end else if (i_sts.mode == ModeBlock && !i_sts.stage_empty) begin
                    n_bcnt  = '0;
                    n_state = S_BDIV;
                end else if (i_sts.mode == ModeQuery && !i_sts.sched_empty) begin
                    o_cmd.q_start = 1'b1;
                    n_state = S_QDIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            // Block number remainder, bit-serial over the 32-bit block number
            S_BDIV: begin
                o_cmd.div_step = 1'b1;
                n_bcnt = r_bcnt + 1'b1;
                if (r_bcnt == 6'd31) n_state = S_CRD;
            end
            S_CRD: begin
                if (!i_sts.bnum_hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.copy_start = 1'b1;
                    n_state = S_CWR;
                    n_bcnt  = '0;
                end
            end
            // Copy: alternate a staging read and a schedule write; last write rewinds the index
            S_CWR: begin
                if (r_bcnt[0] == 1'b0) begin
                    o_cmd.copy_step = 1'b1;
                    n_bcnt = 6'd1;
                end else begin
                    o_cmd.copy_write = 1'b1;
                    n_bcnt = '0;
                    if (i_sts.copy_last) begin
                        o_cmd.copy_done = 1'b1;
                        o_cmd.copy_start = 1'b1;
                        n_built = 1'b1;
                        n_state = S_MIX;
                        n_mcnt  = '0;
                    end
                end
            end
            // Mix: start, then six stages
            S_MIX: begin
                if (r_mcnt == 3'd0) begin
                    o_cmd.mix_start = 1'b1;
                    n_mcnt = 3'd1;
                end else begin
                    o_cmd.mix_step = 1'b1;
                    n_mcnt = r_mcnt + 1'b1;
                    if (r_mcnt == 3'd6) n_state = S_DSTA;
                end
            end
            S_DSTA: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_RDI;
            end
            S_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                o_cmd.rd_j = 1'b1;
                n_state = S_WRI;
            end
            S_WRI: begin
                o_cmd.wr_i = 1'b1;
                n_state = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.wr_j = 1'b1;
                n_mcnt = '0;
                n_state = i_sts.shuf_last ? S_DONE : S_MIX;
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_QRD;
            end
            S_QRD: begin
                o_cmd.q_read = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || w_take) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.copy_done = r_built;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== src/round_schedule_shuffle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_schedule_shuffle
// Staging list, shuffled round schedule and slot lookup.
// ----------------------------------------------------------------------------
// A block update whose number is a multiple of the staging count rebuilds the
// schedule: each id is copied (a staging read, then a schedule write), then each
// position gets a mix, a bit-serial remainder of the 64-bit mix value and a swap.
// One beat in work at a time; the next beat is taken the cycle after the result
// registers, and a held result stalls the next beat only at its end.
// Reset: counts cleared, both lists read as empty; list contents are kept.
module round_schedule_shuffle import rss_pkg::*; #(
    parameter int MAX_PARTICIPANTS = MaxParticipants
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_is_first,
    input  logic [15:0] i_load_id,
    input  logic [31:0] i_block_number,
    input  logic [31:0] i_block_seconds,
    input  logic [63:0] i_current_aslot,
    input  logic [31:0] i_slot_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_picked_id,
    output logic        o_shuffled,
    output logic [1:0]  o_status
);
    t_cmd w_cmd;
    t_sts w_sts;

    rss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rss_datapath #(
        .MAX_PARTICIPANTS (MAX_PARTICIPANTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_is_first      (i_is_first),
        .i_load_id       (i_load_id),
        .i_block_number  (i_block_number),
        .i_block_seconds (i_block_seconds),
        .i_current_aslot (i_current_aslot),
        .i_slot_offset   (i_slot_offset),
        .o_picked_id     (o_picked_id),
        .o_shuffled      (o_shuffled),
        .o_status        (o_status)
    );
endmodule
